// File: rtl/core/cdr_pkg.sv
`timescale 1ns / 1ps

package cdr_pkg;

  // Field types shared by the channel interfaces and the core.
  typedef logic [18:0] secs_t;
  typedef logic [2:0]  edit_pos_t;
  typedef logic [2:0]  digit_pos_t;
  typedef logic [3:0]  digit_t;

  // Configuration port.
  typedef logic [1:0] cfg_idx_t;
  typedef logic [9:0] cfg_data_t;

  localparam cfg_idx_t CFG_REFRESH_PERIOD = 2'd0;
  localparam cfg_idx_t CFG_START_DELAY    = 2'd1;
  localparam cfg_idx_t CFG_BLINK_PERIOD   = 2'd2;

  localparam logic [7:0] REFRESH_PERIOD_RST = 8'd20;
  localparam logic [7:0] START_DELAY_RST    = 8'd100;
  localparam logic [9:0] BLINK_PERIOD_RST   = 10'd1000;

  localparam logic [10:0] SINCE_MAX      = 11'd2047;
  localparam secs_t       SECONDS_MAX    = 19'd359999;
  localparam secs_t       SECS_PER_HOUR  = 19'd3600;

  // Reciprocals for division by 15 (after a shift by two, this gives /60).
  // The first is exact for dividends below 2^17, the second below 2^11.
  localparam logic [17:0] RECIP15_WIDE   = 18'd139811;
  localparam int unsigned RECIP15_WIDE_SH = 21;
  localparam logic [11:0] RECIP15_NARROW = 12'd2185;
  localparam int unsigned RECIP15_NARROW_SH = 15;

endpackage

// File: rtl/core/cdr_if.sv
`timescale 1ns / 1ps

// Tick request channel.
interface cdr_in_if;
  logic                valid;
  logic                ready;
  logic                kind;
  cdr_pkg::secs_t      timer_seconds;
  logic                setup_mode;
  cdr_pkg::edit_pos_t  edit_position;

  modport source (output valid, kind, timer_seconds, setup_mode, edit_position,
                  input ready);
  modport sink (input valid, kind, timer_seconds, setup_mode, edit_position,
                output ready);
endinterface

// Digit write channel.
interface cdr_out_if;
  logic                 valid;
  logic                 ready;
  cdr_pkg::digit_pos_t  digit_position;
  cdr_pkg::digit_t      digit_value;
  logic                 blank;
  logic                 last;

  modport source (output valid, digit_position, digit_value, blank, last,
                  input ready);
  modport sink (input valid, digit_position, digit_value, blank, last,
                output ready);
endinterface

// File: rtl/core/countdown_digit_refresh_core.sv
`timescale 1ns / 1ps

// Countdown display digit refresh core.
// Each request on in_chan is one millisecond tick carrying the time to show,
// the setup flag, the edit position and whether a mode switch happened. The
// core keeps four staggered digit refresh timers and a blink phase, and for
// every digit whose timer expires on that tick it sends one digit write
// request on out_chan, rightmost digit first, with last set on the final
// write of the tick. A tick that expires no timer produces no request.
// A tick's first write is offered once the tick has passed the tick register and
// the minute split; the rest follow one per cycle unless the receiver stalls.
// A tick can be accepted every cycle while in_chan.ready is high; the limit
// is the output channel, which moves one digit write per cycle when the
// receiver is ready. Timer state advances when the tick is accepted, in a
// three stage pipeline: tick register, minute split, then digit registers
// that drain one write per cycle. When the receiver stalls, the digit
// register holds its write and the pipeline fills; in_chan.ready drops
// only when all three stages are full. Reset (rst_n low, synchronous)
// loads the register defaults, empties the pipeline and starts all refresh
// timers together. The user must write configuration through cfg_we /
// cfg_index / cfg_wdata only while the core is idle; the core itself does
// not enforce this.
module countdown_digit_refresh_core (
  input  logic               clk,
  input  logic               rst_n,
  cdr_in_if.sink             in_chan,
  cdr_out_if.source          out_chan,
  input  logic               cfg_we,
  input  cdr_pkg::cfg_idx_t  cfg_index,
  input  cdr_pkg::cfg_data_t cfg_wdata
);
  import cdr_pkg::*;

  // Splits a value below 100 into tens and ones with a compare ladder.
  function automatic logic [7:0] tens_ones(input logic [6:0] v);
    logic [3:0] tens;
    logic [6:0] ones;
    tens = 4'd0;
    for (int i = 1; i <= 9; i++) begin
      if (v >= 7'(10 * i)) begin
        tens = tens + 4'd1;
      end
    end
    ones = v - 7'(({3'b0, tens} << 3) + ({3'b0, tens} << 1));
    return {tens, ones[3:0]};
  endfunction

  // Configuration registers.
  logic [7:0] refresh_r;
  logic [7:0] start_r;
  logic [9:0] blink_r;

  // Timer state.
  logic [10:0] since_r, since_nxt;
  logic [7:0]  slot_r [4];
  logic [7:0]  slot_nxt [4];
  logic [9:0]  blank_cd_r, blank_cd_nxt;
  logic [9:0]  show_cd_r, show_cd_nxt;
  logic        shown_r, shown_nxt;

  // Stage 1: tick register.
  logic        s1_valid_r;
  logic [3:0]  s1_fire_r;
  logic [3:0]  s1_blank_r;
  secs_t       s1_secs_r;
  logic        s1_hhmm_r;

  // Stage 2: total minutes and seconds.
  logic        s2_valid_r;
  logic [3:0]  s2_fire_r;
  logic [3:0]  s2_blank_r;
  logic        s2_hhmm_r;
  logic [12:0] s2_min_r;
  logic [5:0]  s2_sec_r;

  // Stage 3: digit registers that drain one write per cycle when out_chan.ready is high.
  logic [3:0]  s3_mask_r;
  logic [3:0]  s3_blank_r;
  digit_t      s3_digit_r [4];

  // Handshake and flow control.
  logic in_acc, out_acc;
  logic s3_last, s3_free, s2_ready, s1_ready, s2_adv, s1_adv;

  // Tick evaluation.
  logic [3:0]  fire_c;
  logic [3:0]  blank_c;
  logic        hhmm_c;
  secs_t       secs_sat_c;
  logic [2:0]  blink_pos_c;

  // Stage 2 and 3 arithmetic.
  logic [34:0] min_prod;
  logic [12:0] min_total;
  secs_t       min_secs;
  logic [22:0] hour_prod;
  logic [6:0]  hours;
  logic [12:0] hour_mins;
  logic [5:0]  mins;
  logic [7:0]  hour_bcd, min_bcd, sec_bcd;
  digit_t      digit_c [4];

  // Output selection.
  logic [1:0]  out_idx;

  assign out_acc  = out_chan.valid && out_chan.ready;
  assign s3_last  = (s3_mask_r & (s3_mask_r - 4'd1)) == 4'd0;
  assign s3_free  = (s3_mask_r == 4'd0) || (out_chan.ready && s3_last);
  assign s2_ready = !s2_valid_r || s3_free;
  assign s2_adv   = s2_valid_r && s3_free;
  assign s1_ready = !s1_valid_r || s2_ready;
  assign s1_adv   = s1_valid_r && s2_ready;
  assign in_chan.ready = s1_ready;
  assign in_acc   = in_chan.valid && s1_ready;

  // Configuration writes; indexes beyond the register list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      refresh_r <= REFRESH_PERIOD_RST;
      start_r   <= START_DELAY_RST;
      blink_r   <= BLINK_PERIOD_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_REFRESH_PERIOD: refresh_r <= cfg_wdata[7:0];
        CFG_START_DELAY:    start_r   <= cfg_wdata[7:0];
        CFG_BLINK_PERIOD:   blink_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Timer update for the tick being accepted. Each countdown decrements
  // (stopping at zero), is realigned to its period when the time since the
  // last switch reaches its staggered point, and fires and reloads at zero.
  always_comb begin
    logic [10:0] since_upd;
    logic [5:0]  quarter;
    logic [7:0]  slot_dec;
    logic [9:0]  blank_dec, show_dec;
    logic        shown_upd;
    since_upd = (in_chan.kind) ? 11'd0 :
                ((since_r == SINCE_MAX) ? since_r : since_r + 11'd1);
    quarter   = refresh_r[7:2];
    for (int k = 0; k < 4; k++) begin
      slot_dec = (slot_r[k] == 8'd0) ? 8'd0 : slot_r[k] - 8'd1;
      if ({1'b0, since_upd} == 12'(start_r) + 12'(quarter) * 12'(k)) begin
        slot_dec = refresh_r;
      end
      fire_c[k] = (slot_dec == 8'd0);
      if (fire_c[k]) begin
        slot_dec = refresh_r;
      end
      slot_nxt[k] = in_acc ? slot_dec : slot_r[k];
    end

    blank_dec = (blank_cd_r == 10'd0) ? 10'd0 : blank_cd_r - 10'd1;
    show_dec  = (show_cd_r == 10'd0) ? 10'd0 : show_cd_r - 10'd1;
    if ({1'b0, since_upd} == 12'(start_r) + 12'(blink_r[9:1])) begin
      blank_dec = blink_r;
    end
    if ({1'b0, since_upd} == 12'(start_r) + 12'(blink_r)) begin
      show_dec = blink_r;
    end
    shown_upd = shown_r;
    // When both phases expire on the same tick, the digit ends up shown.
    if (blank_dec == 10'd0) begin
      shown_upd = 1'b0;
      blank_dec = blink_r;
    end
    if (show_dec == 10'd0) begin
      shown_upd = 1'b1;
      show_dec  = blink_r;
    end

    since_nxt    = in_acc ? since_upd : since_r;
    blank_cd_nxt = in_acc ? blank_dec : blank_cd_r;
    show_cd_nxt  = in_acc ? show_dec : show_cd_r;
    shown_nxt    = in_acc ? shown_upd : shown_r;

    // Display format and the blinking digit.
    secs_sat_c = (in_chan.timer_seconds > SECONDS_MAX) ? SECONDS_MAX
                                                       : in_chan.timer_seconds;
    blink_pos_c = 3'd0;
    if (in_chan.setup_mode) begin
      case (in_chan.edit_position)
        3'd0:    blink_pos_c = 3'd4;
        3'd1:    blink_pos_c = 3'd3;
        3'd2:    blink_pos_c = 3'd2;
        3'd3:    blink_pos_c = 3'd1;
        3'd4:    blink_pos_c = 3'd2;
        3'd5:    blink_pos_c = 3'd1;
        default: blink_pos_c = 3'd0;
      endcase
    end
    hhmm_c = in_chan.setup_mode ? (in_chan.edit_position <= 3'd3)
                                : (secs_sat_c >= SECS_PER_HOUR);
    for (int k = 0; k < 4; k++) begin
      blank_c[k] = (blink_pos_c == 3'(k + 1)) && !shown_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      since_r    <= SINCE_MAX;
      for (int k = 0; k < 4; k++) begin
        slot_r[k] <= REFRESH_PERIOD_RST;
      end
      blank_cd_r <= BLINK_PERIOD_RST;
      show_cd_r  <= BLINK_PERIOD_RST;
      shown_r    <= 1'b0;
    end else begin
      since_r    <= since_nxt;
      for (int k = 0; k < 4; k++) begin
        slot_r[k] <= slot_nxt[k];
      end
      blank_cd_r <= blank_cd_nxt;
      show_cd_r  <= show_cd_nxt;
      shown_r    <= shown_nxt;
    end
  end

  // Stage 1. Ticks that refresh no digit are dropped here.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_r <= in_acc && (fire_c != 4'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_fire_r  <= fire_c;
      s1_blank_r <= blank_c;
      s1_secs_r  <= secs_sat_c;
      s1_hhmm_r  <= hhmm_c;
    end
  end

  // Stage 2: seconds divided by 60 as (seconds / 4) / 15 by reciprocal.
  assign min_prod  = 35'(s1_secs_r[18:2]) * 35'(RECIP15_WIDE);
  assign min_total = 13'(min_prod >> RECIP15_WIDE_SH);
  assign min_secs  = (19'(min_total) << 6) - (19'(min_total) << 2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_r <= s1_adv;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_fire_r  <= s1_fire_r;
      s2_blank_r <= s1_blank_r;
      s2_hhmm_r  <= s1_hhmm_r;
      s2_min_r   <= min_total;
      s2_sec_r   <= 6'(s1_secs_r - min_secs);
    end
  end

  // Stage 3: hours and minutes, then decimal digits.
  assign hour_prod = 23'(s2_min_r[12:2]) * 23'(RECIP15_NARROW);
  assign hours     = 7'(hour_prod >> RECIP15_NARROW_SH);
  assign hour_mins = (13'(hours) << 6) - (13'(hours) << 2);
  assign mins      = 6'(s2_min_r - hour_mins);
  assign hour_bcd  = tens_ones(hours);
  assign min_bcd   = tens_ones({1'b0, mins});
  assign sec_bcd   = tens_ones({1'b0, s2_sec_r});

  always_comb begin
    if (s2_hhmm_r) begin
      digit_c[0] = min_bcd[3:0];
      digit_c[1] = min_bcd[7:4];
      digit_c[2] = hour_bcd[3:0];
      digit_c[3] = hour_bcd[7:4];
    end else begin
      digit_c[0] = sec_bcd[3:0];
      digit_c[1] = sec_bcd[7:4];
      digit_c[2] = min_bcd[3:0];
      digit_c[3] = min_bcd[7:4];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_mask_r <= 4'd0;
    end else if (s2_adv) begin
      s3_mask_r <= s2_fire_r;
    end else if (out_acc) begin
      s3_mask_r <= s3_mask_r & (s3_mask_r - 4'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      s3_blank_r <= s2_blank_r;
      for (int k = 0; k < 4; k++) begin
        s3_digit_r[k] <= digit_c[k];
      end
    end
  end

  // The lowest pending digit goes out first.
  always_comb begin
    if (s3_mask_r[0]) begin
      out_idx = 2'd0;
    end else if (s3_mask_r[1]) begin
      out_idx = 2'd1;
    end else if (s3_mask_r[2]) begin
      out_idx = 2'd2;
    end else begin
      out_idx = 2'd3;
    end
  end

  assign out_chan.valid          = s3_mask_r != 4'd0;
  assign out_chan.digit_position = {1'b0, out_idx} + 3'd1;
  assign out_chan.blank          = s3_blank_r[out_idx];
  assign out_chan.digit_value    = s3_blank_r[out_idx] ? 4'd0 : s3_digit_r[out_idx];
  assign out_chan.last           = s3_last;

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps

// Testbench for the countdown digit refresh core.
module tb;
  import cdr_pkg::*;

  localparam int CLK_HALF     = 5;
  localparam int RESET_CYCLES = 10;
  // A tick's first write comes from the digit registers after the tick and minute
  // split registers. Waiting after the last write lets the pipeline empty.
  localparam int DRAIN_CYCLES = 10;
  // The slowest correct stretch with no handshake is the largest sender gap plus
  // the pipeline and the largest receiver stall. This limit is far beyond that.
  localparam int IDLE_LIMIT   = 1000;
  localparam int REPORT_MAX   = 10;

  localparam logic TICK_PLAIN  = 1'b0;
  localparam logic TICK_SWITCH = 1'b1;
  localparam logic MODE_RUN    = 1'b0;
  localparam logic MODE_SETUP  = 1'b1;

  // Edit positions 0 to 3 pick an HH:MM digit from the left; 4 and 5 pick the
  // seconds digits of MM:SS; anything above 5 shows MM:SS with nothing blinking.
  localparam edit_pos_t EDIT_HHMM_FIRST = 3'd0;
  localparam edit_pos_t EDIT_HHMM_LAST  = 3'd3;
  localparam edit_pos_t EDIT_SS_TENS    = 3'd4;
  localparam edit_pos_t EDIT_SS_ONES    = 3'd5;
  localparam edit_pos_t EDIT_NONE_LOW   = 3'd6;
  localparam edit_pos_t EDIT_NONE_HIGH  = 3'd7;

  typedef struct packed {
    digit_pos_t pos;
    digit_t     value;
    logic       blank;
    logic       last;
  } digit_write_t;

  logic      clk;
  logic      rst_n;
  logic      cfg_we;
  cfg_idx_t  cfg_index;
  cfg_data_t cfg_wdata;

  cdr_in_if  tick_bus ();
  cdr_out_if write_bus ();

  countdown_digit_refresh_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (tick_bus),
    .out_chan  (write_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Our own copy of the register file and the timer state of the display.
  logic [7:0]  refresh_ms;
  logic [7:0]  delay_ms;
  logic [9:0]  blink_ms;
  logic [10:0] ms_since_switch;
  logic [7:0]  refresh_left [4];
  logic [9:0]  blank_left;
  logic [9:0]  show_left;
  logic        digit_shown;

  // Digit writes that the core still owes, oldest first.
  digit_write_t pending_writes [$];

  // Longest gap before each tick request and longest stall before each digit
  // write; zero turns the idling off for a stretch.
  int tx_max;
  int rx_max;
  int rx_wait;

  int ticks_sent;
  int writes_checked;
  int settings_used;
  int errors;
  int idle_cycles;

  initial begin
    clk = 1'b0;
  end

  always #CLK_HALF clk = ~clk;

  task automatic reset_display_model();
    refresh_ms      = REFRESH_PERIOD_RST;
    delay_ms        = START_DELAY_RST;
    blink_ms        = BLINK_PERIOD_RST;
    ms_since_switch = SINCE_MAX;
    for (int k = 0; k < 4; k++) refresh_left[k] = REFRESH_PERIOD_RST;
    blank_left  = BLINK_PERIOD_RST;
    show_left   = BLINK_PERIOD_RST;
    digit_shown = 1'b0;
  endtask

  // Advances the timers by one millisecond tick and queues the digit writes
  // that this tick causes, rightmost digit first.
  task automatic predict_digit_writes(input logic kind, input secs_t secs,
                                      input logic setup, input edit_pos_t loc);
    int unsigned  quarter;
    int unsigned  origin;
    int unsigned  shown_secs;
    int unsigned  hours;
    int unsigned  mins;
    int unsigned  sec_part;
    int unsigned  blink_pos;
    int           fired;
    int           pushed;
    digit_t       digit_of [4];
    bit           fire [4];
    bit           hhmm;
    digit_write_t w;

    if (kind == TICK_SWITCH) begin
      ms_since_switch = '0;
    end else if (ms_since_switch != SINCE_MAX) begin
      ms_since_switch = ms_since_switch + 1'b1;
    end

    // After a switch each digit timer is pulled back into its own slot, a
    // quarter period after the one to its right.
    quarter = refresh_ms >> 2;
    origin  = delay_ms;
    fired   = 0;
    for (int k = 0; k < 4; k++) begin
      if (refresh_left[k] != 0) refresh_left[k] = refresh_left[k] - 1'b1;
      if (ms_since_switch == origin + k * quarter) refresh_left[k] = refresh_ms;
      fire[k] = (refresh_left[k] == 0);
      if (fire[k]) begin
        refresh_left[k] = refresh_ms;
        fired++;
      end
    end

    // The blank edge realigns half a blink period before the show edge. When
    // both expire on the same tick the show edge wins.
    if (blank_left != 0) blank_left = blank_left - 1'b1;
    if (show_left != 0) show_left = show_left - 1'b1;
    if (ms_since_switch == origin + (blink_ms >> 1)) blank_left = blink_ms;
    if (ms_since_switch == origin + blink_ms) show_left = blink_ms;
    if (blank_left == 0) begin
      digit_shown = 1'b0;
      blank_left  = blink_ms;
    end
    if (show_left == 0) begin
      digit_shown = 1'b1;
      show_left   = blink_ms;
    end

    shown_secs = (secs > SECONDS_MAX) ? SECONDS_MAX : secs;
    hours      = shown_secs / SECS_PER_HOUR;
    mins       = (shown_secs % SECS_PER_HOUR) / 60;
    sec_part   = shown_secs % 60;
    hhmm       = setup ? (loc <= EDIT_HHMM_LAST) : (shown_secs >= SECS_PER_HOUR);
    if (hhmm) begin
      digit_of[0] = digit_t'(mins % 10);
      digit_of[1] = digit_t'(mins / 10);
      digit_of[2] = digit_t'(hours % 10);
      digit_of[3] = digit_t'(hours / 10);
    end else begin
      digit_of[0] = digit_t'(sec_part % 10);
      digit_of[1] = digit_t'(sec_part / 10);
      digit_of[2] = digit_t'(mins % 10);
      digit_of[3] = digit_t'(mins / 10);
    end

    blink_pos = 0;
    if (setup == MODE_SETUP) begin
      if (loc <= EDIT_HHMM_LAST) blink_pos = 4 - loc;
      else if (loc == EDIT_SS_TENS) blink_pos = 2;
      else if (loc == EDIT_SS_ONES) blink_pos = 1;
    end

    pushed = 0;
    for (int k = 0; k < 4; k++) begin
      if (fire[k]) begin
        pushed++;
        w.pos   = digit_pos_t'(k + 1);
        w.blank = (blink_pos == k + 1) && !digit_shown;
        w.value = w.blank ? digit_t'(0) : digit_of[k];
        w.last  = (pushed == fired);
        pending_writes.push_back(w);
      end
    end
  endtask

  task automatic note_failure(input string what);
    errors++;
    if (errors <= REPORT_MAX) $display("%s", what);
  endtask

  // Predicts every accepted tick, checks every accepted digit write and keeps
  // the watchdog that ends a hung run.
  always @(posedge clk) begin : monitor
    bit           accepted;
    digit_write_t got;
    digit_write_t want;

    if (rst_n) begin
      accepted = 1'b0;
      if (tick_bus.valid && tick_bus.ready) begin
        predict_digit_writes(tick_bus.kind, tick_bus.timer_seconds,
                             tick_bus.setup_mode, tick_bus.edit_position);
        ticks_sent++;
        accepted = 1'b1;
      end
      if (write_bus.valid && write_bus.ready) begin
        got.pos   = write_bus.digit_position;
        got.value = write_bus.digit_value;
        got.blank = write_bus.blank;
        got.last  = write_bus.last;
        if (pending_writes.size() == 0) begin
          note_failure($sformatf(
            "Digit write with none pending: pos %0d value %0d blank %0b last %0b",
            got.pos, got.value, got.blank, got.last));
        end else begin
          want = pending_writes.pop_front();
          if (got.pos !== want.pos || got.value !== want.value ||
              got.blank !== want.blank || got.last !== want.last) begin
            note_failure({
              $sformatf("Digit write mismatch at %0t: expected pos %0d value %0d ",
                        $realtime, want.pos, want.value),
              $sformatf("blank %0b last %0b, got pos %0d value %0d blank %0b last %0b",
                        want.blank, want.last, got.pos, got.value, got.blank,
                        got.last)});
          end
        end
        writes_checked++;
        rx_wait  = (rx_max > 0) ? $urandom_range(0, rx_max) : 0;
        accepted = 1'b1;
      end

      idle_cycles = accepted ? 0 : idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Timeout: no request moved for %0d cycles, %0d digit writes pending",
                 IDLE_LIMIT, pending_writes.size());
        $display("FAIL countdown_digit_refresh_core");
        $finish;
      end
    end
  end

  // The display side holds ready low for a drawn number of cycles before each
  // digit write.
  initial begin : write_receiver
    write_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_wait > 0) begin
        write_bus.ready <= 1'b0;
        rx_wait--;
      end else begin
        write_bus.ready <= 1'b1;
      end
    end
  end

  // Sends one tick request after a drawn gap. Valid stays high on return so
  // that back to back ticks keep it up; wait_idle lowers it.
  task automatic send_tick(input logic kind, input secs_t secs,
                           input logic setup, input edit_pos_t loc);
    int gap;

    gap = (tx_max > 0) ? $urandom_range(0, tx_max) : 0;
    @(negedge clk);
    if (gap > 0) begin
      tick_bus.valid <= 1'b0;
      repeat (gap) begin
        tick_bus.kind          <= 1'($urandom);
        tick_bus.timer_seconds <= secs_t'($urandom);
        tick_bus.setup_mode    <= 1'($urandom);
        tick_bus.edit_position <= edit_pos_t'($urandom);
        @(negedge clk);
      end
    end
    tick_bus.valid         <= 1'b1;
    tick_bus.kind          <= kind;
    tick_bus.timer_seconds <= secs;
    tick_bus.setup_mode    <= setup;
    tick_bus.edit_position <= loc;
    do @(posedge clk); while (!tick_bus.ready);
  endtask

  // Stops sending and waits until every owed write has arrived and the
  // pipeline has had time to empty.
  task automatic wait_idle();
    @(negedge clk);
    tick_bus.valid <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input cfg_data_t data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      CFG_REFRESH_PERIOD: refresh_ms = data[7:0];
      CFG_START_DELAY:    delay_ms   = data[7:0];
      CFG_BLINK_PERIOD:   blink_ms   = data;
      default: ;
    endcase
  endtask

  task automatic set_config(input int refresh, input int delay, input int blink);
    write_reg(CFG_REFRESH_PERIOD, cfg_data_t'(refresh));
    write_reg(CFG_START_DELAY, cfg_data_t'(delay));
    write_reg(CFG_BLINK_PERIOD, cfg_data_t'(blink));
    @(negedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // Mostly plain ticks with an occasional mode switch, so that the timers get
  // far enough past a switch to realign. Times cluster around the one hour
  // boundary and the saturation point as well as spreading over the range.
  task automatic send_random_ticks(input int count);
    logic      kind;
    secs_t     secs;
    logic      setup;
    edit_pos_t loc;

    repeat (count) begin
      kind = ($urandom_range(0, 29) == 0) ? TICK_SWITCH : TICK_PLAIN;
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: secs = $urandom_range(0, 3599);
        6, 7:             secs = $urandom_range(3600, 359999);
        8:                secs = $urandom_range(3590, 3610);
        default:          secs = $urandom_range(359990, 524287);
      endcase
      setup = 1'($urandom_range(0, 1));
      loc   = ($urandom_range(0, 9) == 0)
              ? edit_pos_t'($urandom_range(EDIT_NONE_LOW, EDIT_NONE_HIGH))
              : edit_pos_t'($urandom_range(EDIT_HHMM_FIRST, EDIT_SS_ONES));
      send_tick(kind, secs, setup, loc);
    end
  endtask

  // One phase at a given register setting and idling pattern.
  task automatic run_setting(input int refresh, input int delay, input int blink,
                             input int count, input int tx, input int rx);
    wait_idle();
    set_config(refresh, delay, blink);
    tx_max = tx;
    rx_max = rx;
    send_random_ticks(count);
  endtask

  // From reset all four digit timers run together at the default period, so
  // the twentieth tick refreshes every digit at once.
  task automatic test_power_up_refresh();
    tx_max = 0;
    rx_max = 0;
    for (int i = 0; i < 20; i++) begin
      send_tick(TICK_PLAIN, (i == 19) ? SECONDS_MAX : secs_t'(i * 18947),
                MODE_RUN, EDIT_HHMM_FIRST);
    end
  endtask

  // A zero refresh period with a zero start delay makes every tick after the
  // switch refresh all four digits, and a blink period of two alternates the
  // blank phase tick by tick, so each field extreme is seen on every digit.
  task automatic test_field_extremes();
    wait_idle();
    set_config(0, 0, 2);
    tx_max = 0;
    rx_max = 12;
    send_tick(TICK_SWITCH, secs_t'(0), MODE_RUN, EDIT_HHMM_FIRST);
    send_tick(TICK_PLAIN, SECONDS_MAX, MODE_RUN, EDIT_HHMM_FIRST);
    // Above 99:59:59 the time saturates before it is split into digits.
    send_tick(TICK_PLAIN, secs_t'('1), MODE_RUN, EDIT_NONE_HIGH);
    // Just below and at one hour, where run mode changes format.
    send_tick(TICK_PLAIN, secs_t'(3599), MODE_RUN, EDIT_HHMM_FIRST);
    send_tick(TICK_PLAIN, SECS_PER_HOUR, MODE_RUN, EDIT_HHMM_FIRST);
    // Every edit position in setup mode, including the two that blink nothing.
    for (int p = EDIT_HHMM_FIRST; p <= EDIT_NONE_HIGH; p++) begin
      send_tick(TICK_PLAIN, secs_t'(3600 * p * 13 + 754), MODE_SETUP,
                edit_pos_t'(p));
    end
  endtask

  task automatic test_fastest_settings();
    run_setting(4, 0, 2, 30, 0, 0);
  endtask

  task automatic test_random_settings();
    repeat (2) begin
      run_setting($urandom_range(4, 12), $urandom_range(0, 20),
                  $urandom_range(2, 40), 20, 12, 12);
    end
  endtask

  task automatic test_slowest_settings();
    run_setting(255, 255, 1023, 20, 12, 12);
  endtask

  // With the display stalling and ticks arriving every cycle, the pipeline
  // fills and the tick channel has to push back.
  task automatic test_output_backpressure();
    run_setting($urandom_range(4, 8), $urandom_range(0, 10),
                $urandom_range(2, 30), 40, 0, 12);
  endtask

  task automatic test_input_gaps();
    run_setting($urandom_range(4, 12), $urandom_range(0, 20),
                $urandom_range(2, 40), 40, 12, 0);
  endtask

  // Periods below the supported range: short refresh periods fire on a third
  // of the ticks or more, and blink periods of zero or one make blank and show
  // expire together.
  task automatic test_below_range_periods();
    run_setting($urandom_range(0, 3), $urandom_range(0, 5), $urandom_range(0, 1),
                30, 6, 6);
  endtask

  initial begin : stimulus
    rst_n                  = 1'b0;
    cfg_we                 = 1'b0;
    cfg_index              = CFG_REFRESH_PERIOD;
    cfg_wdata              = '0;
    tick_bus.valid         = 1'b0;
    tick_bus.kind          = TICK_PLAIN;
    tick_bus.timer_seconds = '0;
    tick_bus.setup_mode    = MODE_RUN;
    tick_bus.edit_position = EDIT_HHMM_FIRST;
    tx_max                 = 0;
    rx_max                 = 0;
    rx_wait                = 0;
    ticks_sent             = 0;
    writes_checked         = 0;
    settings_used          = 0;
    errors                 = 0;
    idle_cycles            = 0;
    reset_display_model();

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_power_up_refresh();
    test_field_extremes();
    test_fastest_settings();
    test_random_settings();
    test_slowest_settings();
    test_output_backpressure();
    test_input_gaps();
    test_below_range_periods();
    wait_idle();

    $display("Sent %0d ticks and checked %0d digit writes across %0d register settings,",
             ticks_sent, writes_checked, settings_used + 1);
    $display("with and without random gaps on the tick side and stalls on the display side.");
    if (errors == 0) begin
      $display("PASS countdown_digit_refresh_core");
    end else begin
      $display("%0d digit write errors", errors);
      $display("FAIL countdown_digit_refresh_core");
    end
    $finish;
  end

endmodule
